// ===== rtl/core/skf_pkg.sv =====
// Package for the scalar Kalman filter: widths, codes and control types.
package skf_pkg;

  localparam int SAMPLE_WIDTH   = 16;
  localparam int GAIN_FRAC_BITS = 16;

  localparam int VAL_W   = 24;                      // estimate, covariance, noise terms
  localparam int DEN_W   = VAL_W + 1;               // pm + R
  localparam int REM_W   = DEN_W + 1;               // divider partial remainder
  localparam int GAIN_W  = GAIN_FRAC_BITS + 1;      // gain, 0 .. 1.0
  localparam int MAG_W   = VAL_W + 1;               // |s - x|
  localparam int PROD_W  = MAG_W + GAIN_W;          // shared multiplier product
  localparam int STEP_W  = PROD_W + 1 - GAIN_FRAC_BITS;
  localparam int NX_W    = STEP_W + 1;              // x +/- step before clamp
  localparam int EXT_W   = (SAMPLE_WIDTH + 8 > VAL_W) ? SAMPLE_WIDTH + 8 : VAL_W;
  localparam int DIV_STEPS = GAIN_FRAC_BITS + 1;
  localparam int CNT_W   = $clog2(DIV_STEPS + 1);

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE = CFG_IDX_W'(1);

  localparam logic [VAL_W-1:0] PROCESS_NOISE_RST = VAL_W'(6554);
  localparam logic [VAL_W-1:0] MEASURE_NOISE_RST = VAL_W'(66);

  localparam logic [GAIN_W-1:0] GAIN_ONE  = GAIN_W'(1) << GAIN_FRAC_BITS;
  localparam logic [PROD_W:0]   ROUND_HALF = (PROD_W + 1)'(1) << (GAIN_FRAC_BITS - 1);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_PREP = 7'b0000010,
    ST_DIV  = 7'b0000100,
    ST_MULX = 7'b0001000,
    ST_MULP = 7'b0010000,
    ST_UPDP = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_t;

  typedef struct packed {
    logic accept;     // latch sample, form predicted covariance
    logic prep;       // form divisor, seed divider
    logic div_step;   // one quotient bit
    logic mul_x;      // product for the estimate step
    logic mul_p;      // update estimate, product for covariance
    logic upd_p;      // update covariance
    logic load_out;   // move estimate into output register
  } cmd_t;

  typedef struct packed {
    logic out_free;   // output register can take a beat this cycle
  } sts_t;

endpackage

// ===== rtl/core/skf_intf.sv =====
// Channel interfaces: sample input, estimate output, configuration writes.
interface skf_sample_if;
  import skf_pkg::*;
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface skf_estimate_if;
  import skf_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] estimate;
  modport source (output valid, output estimate, input ready);
  modport sink (input valid, input estimate, output ready);
endinterface

interface skf_cfg_if;
  import skf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/skf_ctrl.sv =====
// Controller FSM: sequences accept, divide, two multiplies and output load.
module skf_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  skf_pkg::sts_t sts,
  output skf_pkg::cmd_t cmd
);
  import skf_pkg::*;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        cnt_next   = '0;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + CNT_W'(1);
        if (cnt == CNT_W'(DIV_STEPS - 1)) state_next = ST_MULX;
      end
      ST_MULX: begin
        cmd.mul_x  = 1'b1;
        state_next = ST_MULP;
      end
      ST_MULP: begin
        cmd.mul_p  = 1'b1;
        state_next = ST_UPDP;
      end
      ST_UPDP: begin
        cmd.upd_p  = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

// ===== rtl/core/skf_dp.sv =====
// Datapath: noise registers, filter state, restoring divider, shared multiplier.
module skf_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  skf_pkg::cmd_t                          cmd,
  output skf_pkg::sts_t                          sts,
  input  logic signed [skf_pkg::SAMPLE_WIDTH-1:0] sample,
  input  logic                                   cfg_we,
  input  logic [skf_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [skf_pkg::CFG_DATA_W-1:0]         cfg_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [skf_pkg::VAL_W-1:0]       out_estimate
);
  import skf_pkg::*;

  localparam logic signed [EXT_W-1:0] S_MAX = EXT_W'(signed'(VAL_W'(8388607)));
  localparam logic signed [EXT_W-1:0] S_MIN = -S_MAX - EXT_W'(1);
  localparam logic signed [NX_W-1:0]  X_MAX = NX_W'(S_MAX);
  localparam logic signed [NX_W-1:0]  X_MIN = NX_W'(S_MIN);

  logic [VAL_W-1:0]        proc_noise, meas_noise;
  logic signed [VAL_W-1:0] est_x;
  logic [VAL_W-1:0]        cov_p;
  logic signed [VAL_W-1:0] samp_s;
  logic [VAL_W-1:0]        pm;
  logic [DEN_W-1:0]        den;
  logic [REM_W-1:0]        rem;
  logic [GAIN_W-1:0]       quo;
  logic [PROD_W-1:0]       prod;

  // sample scaled to Q15.8 with saturation
  logic signed [EXT_W-1:0] samp_ext, samp_sc;
  logic signed [VAL_W-1:0] samp_sat;
  always_comb begin
    samp_ext = EXT_W'(sample);
    samp_sc  = samp_ext <<< 8;
    if (samp_sc > S_MAX)      samp_sat = S_MAX[VAL_W-1:0];
    else if (samp_sc < S_MIN) samp_sat = S_MIN[VAL_W-1:0];
    else                      samp_sat = samp_sc[VAL_W-1:0];
  end

  // predicted covariance, saturating
  logic [VAL_W:0] pm_sum;
  assign pm_sum = {1'b0, cov_p} + {1'b0, proc_noise};

  // divider step
  logic           div_ge;
  logic [REM_W-1:0] div_sub;
  assign div_ge  = rem >= {1'b0, den};
  assign div_sub = div_ge ? rem - {1'b0, den} : rem;

  logic [GAIN_W-1:0] gain;
  assign gain = (den == '0) ? '0 : quo;

  // estimate step
  logic signed [MAG_W-1:0] diff;
  logic                    neg;
  logic [MAG_W-1:0]        mag;
  assign diff = MAG_W'(samp_s) - MAG_W'(est_x);
  assign neg  = diff[MAG_W-1];
  assign mag  = neg ? MAG_W'(-diff) : MAG_W'(diff);

  // shared multiplier
  logic [MAG_W-1:0]  mul_a;
  logic [GAIN_W-1:0] mul_b;
  assign mul_a = cmd.mul_p ? MAG_W'(pm) : mag;
  assign mul_b = cmd.mul_p ? GAIN_ONE - gain : gain;

  logic [PROD_W:0]          prod_rnd;
  logic [STEP_W-1:0]        step;
  logic signed [NX_W-1:0]   nx;
  logic signed [VAL_W-1:0]  nx_sat;
  always_comb begin
    prod_rnd = {1'b0, prod} + ROUND_HALF;
    step     = prod_rnd[PROD_W:GAIN_FRAC_BITS];
    nx       = neg ? NX_W'(est_x) - NX_W'({1'b0, step})
                   : NX_W'(est_x) + NX_W'({1'b0, step});
    if (nx > X_MAX)      nx_sat = X_MAX[VAL_W-1:0];
    else if (nx < X_MIN) nx_sat = X_MIN[VAL_W-1:0];
    else                 nx_sat = nx[VAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      proc_noise <= PROCESS_NOISE_RST;
      meas_noise <= MEASURE_NOISE_RST;
      est_x      <= '0;
      cov_p      <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == REG_PROCESS_NOISE) proc_noise <= cfg_data[VAL_W-1:0];
      if (cfg_we && cfg_index == REG_MEASURE_NOISE) meas_noise <= cfg_data[VAL_W-1:0];
      if (cmd.mul_p) est_x <= nx_sat;
      if (cmd.upd_p) cov_p <= prod_rnd[GAIN_FRAC_BITS +: VAL_W];
      if (cmd.load_out)                 out_valid <= 1'b1;
      else if (out_valid && out_ready)  out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      samp_s <= samp_sat;
      pm     <= pm_sum[VAL_W] ? '1 : pm_sum[VAL_W-1:0];
    end
    if (cmd.prep) begin
      den <= {1'b0, pm} + {1'b0, meas_noise};
      rem <= REM_W'(pm);
      quo <= '0;
    end
    if (cmd.div_step) begin
      rem <= {div_sub[REM_W-2:0], 1'b0};
      quo <= {quo[GAIN_W-2:0], div_ge};
    end
    if (cmd.mul_x || cmd.mul_p) prod <= mul_a * mul_b;
    if (cmd.load_out) out_estimate <= est_x;
  end

  assign sts.out_free = !out_valid || out_ready;

endmodule

// ===== rtl/core/scalar_kalman_filter_top.sv =====
// Top level of the scalar Kalman filter: channels, controller and datapath.
//
// Usage:
//   samples   - sink channel; one beat carries one signed raw sensor sample.
//   estimates - source channel; one beat carries the filtered estimate
//               (signed Q15.8) that results from one sample.
//   cfg       - write-only channel; index 0 sets process noise Q, index 1
//               sets measurement noise R (unsigned Q8.16, low 24 bits of data).
//               Other indices are ignored. cfg.ready is always high; write only
//               while the filter is idle.
// Timing: one sample in flight at a time. After the input beat, a setup
//   state, the restoring divider (one gain bit per cycle), two multiplier
//   states and one covariance update state precede the output load. A new
//   sample is taken only once the estimate has moved into the output
//   register. The divider takes the largest share of the time per sample.
// Stall: the output register holds the estimate until taken; if it is still
//   full when the next result is ready, the filter waits and samples.ready
//   stays low.
// Reset (rst, synchronous): estimate and covariance clear to zero, Q and R
//   return to their defaults, the output register empties.
module scalar_kalman_filter_top (
  input logic      clk,
  input logic      rst,
  skf_sample_if.sink     samples,
  skf_estimate_if.source estimates,
  skf_cfg_if.sink        cfg
);
  import skf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // configuration channel never stalls
  assign cfg.ready = 1'b1;

  skf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (samples.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  skf_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .sample       (samples.sample),
    .cfg_we       (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .out_valid    (estimates.valid),
    .out_ready    (estimates.ready),
    .out_estimate (estimates.estimate)
  );

endmodule

// ===== rtl/core/skf_checker.sv =====
// Port-level checks for the scalar Kalman filter, bound to the top level.
module skf_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [skf_pkg::VAL_W-1:0]  out_estimate
);
  import skf_pkg::*;

  // one sample in flight: no beat right after a taken beat
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted back to back");

  // a result never appears in the cycle right after an input beat
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result too early");

  // reset empties the output and opens the input
  a_reset_state: assert property (@(posedge clk)
    rst |=> (!out_valid && in_ready))
    else $error("bad state after reset");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_estimate)))
    else $error("stalled result changed");

endmodule

bind scalar_kalman_filter_top skf_checker u_skf_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (samples.valid),
  .in_ready     (samples.ready),
  .out_valid    (estimates.valid),
  .out_ready    (estimates.ready),
  .out_estimate (estimates.estimate)
);
